// File: hdl/pcbm_pkg.sv
// ----------------------------------------------------------------------------
// pcbm_pkg - shared types for the paired-channel block median filter
// Sample type, item structs for both channels, set codes and the control
// group that drives the sorting chain.
// ----------------------------------------------------------------------------
package pcbm_pkg;

	localparam int SAMPLE_W = 12;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// set codes carried in set_kind
	localparam logic SET_NORMAL = 1'b0;
	localparam logic SET_KNOWN  = 1'b1;

	typedef struct packed {
		sample_t sample;
		logic    known_load;
	} sample_item_t;

	typedef struct packed {
		logic    set_kind;
		sample_t fwd_median;
		sample_t ref_median;
	} median_item_t;

	// control shared by every cell of a sorting chain
	typedef struct packed {
		logic clear;
		logic shift;
	} chain_ctl_t;

endpackage

// File: hdl/pcbm_sort_cell.sv
// ----------------------------------------------------------------------------
// pcbm_sort_cell - one cell of the systolic insertion sorter
// Keeps the smaller of its held value and the incoming one and hands the
// larger to its right neighbor through a register. In shift mode it takes the
// held value of its right neighbor.
// ----------------------------------------------------------------------------
module pcbm_sort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcbm_pkg::chain_ctl_t ctl,
	input  logic                 in_vld,
	input  pcbm_pkg::sample_t    in_val,
	input  pcbm_pkg::sample_t    next_hold,
	output logic                 out_vld,
	output pcbm_pkg::sample_t    out_val,
	output pcbm_pkg::sample_t    hold
);
	import pcbm_pkg::*;

	logic    hold_vld_q;
	logic    pass_vld_q;
	sample_t hold_q;
	sample_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctl.clear) begin
			hold_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctl.shift) begin
			pass_vld_q <= 1'b0;
		end else begin
			// an occupied cell pushes one value onward for each value it takes in
			pass_vld_q <= in_vld && hold_vld_q;
			if (in_vld) begin
				hold_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hold_q <= next_hold;
		end else if (in_vld && !ctl.clear) begin
			if (!hold_vld_q) begin
				hold_q <= in_val;
			end else if (in_val < hold_q) begin
				hold_q <= in_val;
				pass_q <= hold_q;
			end else begin
				pass_q <= in_val;
			end
		end
	end

	assign out_vld = pass_vld_q;
	assign out_val = pass_q;
	assign hold    = hold_q;

endmodule

// File: hdl/pcbm_window_ram.sv
// ----------------------------------------------------------------------------
// pcbm_window_ram - storage for one sample window
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module pcbm_window_ram #(
	parameter int WINDOW = 24
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(WINDOW)-1:0] wr_addr,
	input  pcbm_pkg::sample_t         wr_data,
	input  logic [$clog2(WINDOW)-1:0] rd_addr,
	output pcbm_pkg::sample_t         rd_data
);
	import pcbm_pkg::*;

	sample_t mem_q [WINDOW];
	sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/pcbm_sort_chain.sv
// ----------------------------------------------------------------------------
// pcbm_sort_chain - row of sort cells for one window
// Values enter at the left end one per cycle and settle in ascending order,
// smallest in the leftmost cell. Shift mode moves the sorted row out through
// the head one value per cycle.
// ----------------------------------------------------------------------------
module pcbm_sort_chain #(
	parameter int WINDOW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcbm_pkg::chain_ctl_t ctl,
	input  logic                 feed_vld,
	input  pcbm_pkg::sample_t    feed_val,
	output pcbm_pkg::sample_t    head,
	output pcbm_pkg::sample_t    median,
	output logic                 spill
);
	import pcbm_pkg::*;

	localparam int HALF = WINDOW / 2;

	logic    link_vld [WINDOW+1];
	sample_t link_val [WINDOW];
	sample_t hold_val [WINDOW];

	assign link_vld[0] = feed_vld;
	assign link_val[0] = feed_val;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i < WINDOW - 1) begin : g_mid
			pcbm_sort_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.in_vld    (link_vld[i]),
				.in_val    (link_val[i]),
				.next_hold (hold_val[i+1]),
				.out_vld   (link_vld[i+1]),
				.out_val   (link_val[i+1]),
				.hold      (hold_val[i])
			);
		end else begin : g_last
			pcbm_sort_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.in_vld    (link_vld[i]),
				.in_val    (link_val[i]),
				.next_hold ('0),
				.out_vld   (link_vld[i+1]),
				.out_val   (),
				.hold      (hold_val[i])
			);
		end
	end

	if ((WINDOW % 2) == 0) begin : g_even
		logic [SAMPLE_W:0] mid_sum;
		// floor mean of the two middle values
		assign mid_sum = {1'b0, hold_val[HALF]} + {1'b0, hold_val[HALF-1]};
		assign median  = mid_sum[SAMPLE_W:1];
	end else begin : g_odd
		assign median = hold_val[HALF];
	end

	assign head  = hold_val[0];
	assign spill = link_vld[WINDOW];

endmodule

// File: hdl/paired_channel_block_median.sv
// ----------------------------------------------------------------------------
// paired_channel_block_median - block median over alternating channel pairs
// Routes forward/reflected samples into the normal or known-load windows and
// emits both channel medians of a set once it holds WINDOW pairs.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------
//  samples   | sample_valid / sample_stall | sample_item (sample, known_load)
//  medians   | median_valid / median_stall | median_item (set_kind, fwd, ref)
//
// An item that finds no full set is stored at once and raises no stall. An
// item that closes a set raises sample_stall and is held while WINDOW reads
// feed the two sort chains, the chains settle as the last value walks to the
// far end, the sorted windows go back through the write port of each RAM of
// the set, and the output register loads; the held item is stored then.
// The emit cycle waits while a previous result is still stalled.
// Reset clears fills, channel phase and all valid bits; window contents are
// left as they are.
// ----------------------------------------------------------------------------
module paired_channel_block_median #(
	parameter int WINDOW = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  pcbm_pkg::sample_item_t sample_item,
	output logic                   median_valid,
	input  logic                   median_stall,
	output pcbm_pkg::median_item_t median_item
);
	import pcbm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int IDX_W = $clog2(WINDOW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WBACK = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             expect_q;
	logic [CNT_W-1:0] normal_fill_q;
	logic [CNT_W-1:0] known_fill_q;
	logic             sel_known_q;
	logic             feed_vld_s1;
	logic             out_valid_q;
	sample_t          pend_smp_q;
	logic             pend_known_q;
	sample_t          med_fwd_q;
	sample_t          med_ref_q;
	median_item_t     out_q;

	logic             accept_in;
	logic             normal_full;
	logic             known_full;
	logic             any_full;
	logic             out_free;
	logic             emit_go;
	logic             wback;
	logic             last_idx;
	logic             st_en;
	logic             st_known;
	sample_t          st_smp;
	logic [CNT_W-1:0] normal_fill_eff;
	logic [CNT_W-1:0] known_fill_eff;
	logic [CNT_W-1:0] normal_fill_n;
	logic [CNT_W-1:0] known_fill_n;
	logic [IDX_W-1:0] st_idx;
	logic [IDX_W-1:0] ram_wr_idx;
	logic [IDX_W-1:0] ram_rd_idx;

	sample_t          nf_rd, nr_rd, kf_rd, kr_rd;
	sample_t          fwd_head, ref_head;
	sample_t          fwd_median, ref_median;
	logic             fwd_spill, ref_spill;
	chain_ctl_t       chain_ctl;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept_in    = sample_valid && !sample_stall;
	assign normal_full  = (normal_fill_q >= CNT_W'(WINDOW));
	assign known_full   = (known_fill_q >= CNT_W'(WINDOW));
	assign any_full     = normal_full || known_full;
	assign out_free     = !out_valid_q || !median_stall;
	assign emit_go      = (state_q == ST_EMIT) && out_free;
	assign wback        = (state_q == ST_WBACK);
	assign last_idx     = (cnt_q == CNT_W'(WINDOW - 1));

	// sample store: straight from the port, or the held item after a median
	always_comb begin
		st_en    = 1'b0;
		st_known = 1'b0;
		st_smp   = sample_item.sample;
		if (accept_in && !any_full) begin
			st_en    = 1'b1;
			st_known = sample_item.known_load;
		end else if (emit_go) begin
			st_en    = 1'b1;
			st_known = pend_known_q;
			st_smp   = pend_smp_q;
		end
	end

	// the closing set restarts at zero before the held sample lands
	assign normal_fill_eff = (emit_go && sel_known_q == SET_NORMAL) ? '0 : normal_fill_q;
	assign known_fill_eff  = (emit_go && sel_known_q == SET_KNOWN)  ? '0 : known_fill_q;
	assign normal_fill_n   = normal_fill_eff + CNT_W'(st_en && !st_known && expect_q);
	assign known_fill_n    = known_fill_eff  + CNT_W'(st_en &&  st_known && expect_q);
	assign st_idx          = st_known ? known_fill_eff[IDX_W-1:0] : normal_fill_eff[IDX_W-1:0];
	assign ram_wr_idx      = wback ? cnt_q[IDX_W-1:0] : st_idx;
	assign ram_rd_idx      = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			expect_q      <= 1'b0;
			normal_fill_q <= '0;
			known_fill_q  <= '0;
			sel_known_q   <= SET_NORMAL;
			feed_vld_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			normal_fill_q <= normal_fill_n;
			known_fill_q  <= known_fill_n;
			feed_vld_s1   <= (state_q == ST_LOAD);
			if (st_en) begin
				expect_q <= !expect_q;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!median_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in && any_full) begin
						state_q     <= ST_LOAD;
						cnt_q       <= '0;
						sel_known_q <= known_full ? SET_KNOWN : SET_NORMAL;
					end
				end
				ST_LOAD: begin
					if (last_idx) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// let the last value walk to the far end of the chain
					if (cnt_q == CNT_W'(WINDOW)) begin
						state_q <= ST_WBACK;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WBACK: begin
					if (last_idx) begin
						state_q <= ST_EMIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && any_full) begin
			pend_smp_q <= sample_item.sample;
			// closing the known set drops the known-load route for this item
			pend_known_q <= sample_item.known_load && !known_full;
		end
		if (state_q == ST_DRAIN && cnt_q == CNT_W'(WINDOW)) begin
			med_fwd_q <= fwd_median;
			med_ref_q <= ref_median;
		end
		if (emit_go) begin
			out_q.set_kind   <= sel_known_q;
			out_q.fwd_median <= med_fwd_q;
			out_q.ref_median <= med_ref_q;
		end
	end

	assign median_valid = out_valid_q;
	assign median_item  = out_q;

	pcbm_window_ram #(.WINDOW(WINDOW)) u_normal_fwd (
		.clk     (clk),
		.wr_en   ((st_en && !st_known && !expect_q) || (wback && sel_known_q == SET_NORMAL)),
		.wr_addr (ram_wr_idx),
		.wr_data (wback ? fwd_head : st_smp),
		.rd_addr (ram_rd_idx),
		.rd_data (nf_rd)
	);

	pcbm_window_ram #(.WINDOW(WINDOW)) u_normal_ref (
		.clk     (clk),
		.wr_en   ((st_en && !st_known && expect_q) || (wback && sel_known_q == SET_NORMAL)),
		.wr_addr (ram_wr_idx),
		.wr_data (wback ? ref_head : st_smp),
		.rd_addr (ram_rd_idx),
		.rd_data (nr_rd)
	);

	pcbm_window_ram #(.WINDOW(WINDOW)) u_known_fwd (
		.clk     (clk),
		.wr_en   ((st_en && st_known && !expect_q) || (wback && sel_known_q == SET_KNOWN)),
		.wr_addr (ram_wr_idx),
		.wr_data (wback ? fwd_head : st_smp),
		.rd_addr (ram_rd_idx),
		.rd_data (kf_rd)
	);

	pcbm_window_ram #(.WINDOW(WINDOW)) u_known_ref (
		.clk     (clk),
		.wr_en   ((st_en && st_known && expect_q) || (wback && sel_known_q == SET_KNOWN)),
		.wr_addr (ram_wr_idx),
		.wr_data (wback ? ref_head : st_smp),
		.rd_addr (ram_rd_idx),
		.rd_data (kr_rd)
	);

	assign chain_ctl.clear = accept_in && any_full;
	assign chain_ctl.shift = wback;

	pcbm_sort_chain #(.WINDOW(WINDOW)) u_fwd_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (chain_ctl),
		.feed_vld (feed_vld_s1),
		.feed_val ((sel_known_q == SET_KNOWN) ? kf_rd : nf_rd),
		.head     (fwd_head),
		.median   (fwd_median),
		.spill    (fwd_spill)
	);

	pcbm_sort_chain #(.WINDOW(WINDOW)) u_ref_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (chain_ctl),
		.feed_vld (feed_vld_s1),
		.feed_val ((sel_known_q == SET_KNOWN) ? kr_rd : nr_rd),
		.head     (ref_head),
		.median   (ref_median),
		.spill    (ref_spill)
	);

	// a window never holds more values than the chain has cells
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!(fwd_spill || ref_spill))
		else $error("sort chain pushed a value past its last cell");

	a_one_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(normal_full && known_full))
		else $error("both window sets full at once");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		normal_fill_q <= CNT_W'(WINDOW) && known_fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window size");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(state_q) == ST_EMIT)
		else $error("result raised outside the emit step");

endmodule

// File: verif/tb_paired_channel_block_median.sv
// ----------------------------------------------------------------------------
// tb_paired_channel_block_median - self-checking bench for the block median
// Streams forward/reflected sample pairs into the normal and known-load sets
// and predicts every median item from a local copy of the windows. Each
// median item is checked field by field against the oldest prediction.
// Both sides insert random wait cycles.
// ----------------------------------------------------------------------------
module tb_paired_channel_block_median;
	timeunit 1ns;
	timeprecision 1ps;

	import pcbm_pkg::*;

	localparam int WINDOW = 24;
	localparam int CH_FWD = 0;
	localparam int CH_REF = 1;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 100;

	typedef enum int {FILL_ANY, FILL_ZERO, FILL_MAX, FILL_RAILS, FILL_NARROW} fill_style_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         sample_valid = 1'b0;
	logic         sample_stall;
	sample_item_t sample_item = '0;
	logic         median_valid;
	logic         median_stall = 1'b0;
	median_item_t median_item;

	// predicted block state, indexed by set code then channel
	sample_t          win [2][2][WINDOW];
	int               pair_fill [2];
	logic             reflected_next;
	logic             last_fwd_set;
	logic [WINDOW-1:0] fwd_written [2];

	median_item_t pending_medians [$];

	int send_gap_max = 8;
	int recv_gap_max = 8;
	int stall_left = 0;
	int items_sent = 0;
	int medians_seen [2];
	int mixed_pairs = 0;
	int forced_normal = 0;
	int errors = 0;
	int idle_cycles = 0;

	paired_channel_block_median #(.WINDOW(WINDOW)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.median_valid (median_valid),
		.median_stall (median_stall),
		.median_item  (median_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// sort the window in place (it stays sorted) and return its median
	function automatic sample_t sort_median(input int s, input int ch);
		sample_t t;
		for (int a = 0; a < WINDOW - 1; a++)
			for (int b = a + 1; b < WINDOW; b++)
				if (win[s][ch][b] < win[s][ch][a]) begin
					t = win[s][ch][a];
					win[s][ch][a] = win[s][ch][b];
					win[s][ch][b] = t;
				end
		if (WINDOW % 2 != 0)
			return win[s][ch][WINDOW/2];
		return sample_t'(({1'b0, win[s][ch][WINDOW/2]} + {1'b0, win[s][ch][WINDOW/2-1]}) >> 1);
	endfunction

	task automatic apply_sample(input sample_t smp, input logic known);
		median_item_t m;
		logic route;
		route = known;
		for (int s = 0; s < 2; s++)
			if (pair_fill[s] >= WINDOW) begin
				pair_fill[s] = 0;
				m.set_kind = (s == SET_KNOWN) ? SET_KNOWN : SET_NORMAL;
				m.fwd_median = sort_median(s, CH_FWD);
				m.ref_median = sort_median(s, CH_REF);
				pending_medians.push_back(m);
				// closing the known set releases the load for this item
				if (s == SET_KNOWN) begin
					if (known == SET_KNOWN)
						forced_normal++;
					route = SET_NORMAL;
				end
			end
		if (!reflected_next) begin
			win[route][CH_FWD][pair_fill[route]] = smp;
			fwd_written[route][pair_fill[route]] = 1'b1;
			last_fwd_set = route;
			reflected_next = 1'b1;
		end else begin
			if (route != last_fwd_set)
				mixed_pairs++;
			win[route][CH_REF][pair_fill[route]] = smp;
			pair_fill[route]++;
			reflected_next = 1'b0;
		end
	endtask

	task automatic send_item(input sample_t smp, input logic known);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_item <= '{sample: smp, known_load: known};
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		items_sent++;
		apply_sample(smp, known);
	endtask

	// a reflected sample may leave its forward's set only once every forward
	// entry of both sets holds data, so no median reads an unwritten entry
	task automatic send_pair(input sample_t f, input sample_t r, input logic set,
			input int mix_pct);
		logic kf, kr;
		kf = set;
		if ($urandom_range(0, 99) < mix_pct)
			kf = ~set;
		send_item(f, kf);
		kr = last_fwd_set;
		if ((&fwd_written[SET_NORMAL]) && (&fwd_written[SET_KNOWN]) &&
				$urandom_range(0, 99) < mix_pct)
			kr = ~last_fwd_set;
		send_item(r, kr);
	endtask

	function automatic sample_t draw_value(input fill_style_t style, input sample_t base);
		case (style)
			FILL_ZERO:   return '0;
			FILL_MAX:    return '1;
			FILL_RAILS:  return $urandom_range(0, 1) ? '1 : '0;
			FILL_NARROW: return base + sample_t'($urandom_range(0, 3));
			default:     return sample_t'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send_run(input int pairs, input logic set, input int mix_pct);
		fill_style_t style;
		sample_t base;
		style = fill_style_t'($urandom_range(0, 4));
		base = sample_t'($urandom_range(0, 4092));
		repeat (pairs)
			send_pair(draw_value(style, base), draw_value(style, base), set, mix_pct);
	endtask

	task automatic test_directed;
		send_pair(12'h000, 12'h000, SET_NORMAL, 0);
		send_pair(12'hFFF, 12'hFFF, SET_NORMAL, 0);
		send_pair(12'hAAA, 12'h555, SET_KNOWN, 0);
		send_pair(12'h555, 12'hAAA, SET_KNOWN, 0);
		send_pair(12'hFFF, 12'h000, SET_NORMAL, 0);
		send_pair(12'h000, 12'hFFF, SET_KNOWN, 0);
		send_pair(12'h001, 12'h800, SET_NORMAL, 0);
		send_pair(12'h800, 12'h001, SET_KNOWN, 0);
		send_pair(12'h7FF, 12'hFFE, SET_NORMAL, 0);
		send_pair(12'hFFE, 12'h7FF, SET_KNOWN, 0);
		// forward diverted to the other set, reflected follows it
		send_pair(12'h123, 12'h456, SET_NORMAL, 100);
		send_pair(12'hFED, 12'hCBA, SET_KNOWN, 100);
	endtask

	task automatic test_random_sets(input int target);
		while (items_sent < target)
			send_run($urandom_range(1, 30), 1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? 20 : 0);
	endtask

	task automatic test_back_to_back(input int count);
		int stop_at;
		stop_at = items_sent + count;
		send_gap_max = 0;
		recv_gap_max = 0;
		while (items_sent < stop_at)
			send_run($urandom_range(4, 30), 1'($urandom_range(0, 1)), 10);
		send_gap_max = 8;
		recv_gap_max = 8;
	endtask

	// hold the sample side until every predicted median has been taken
	task automatic test_drain_pause;
		repeat (3) begin
			while (pending_medians.size() == 0)
				send_pair(sample_t'($urandom_range(0, 4095)),
					sample_t'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)), 0);
			@(negedge clk);
			sample_valid <= 1'b0;
			wait (pending_medians.size() == 0);
		end
	endtask

	always @(negedge clk) begin
		if (median_valid && stall_left > 0) begin
			median_stall <= 1'b1;
			stall_left--;
		end else begin
			median_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		median_item_t want;
		if (arst_n && median_valid && !median_stall) begin
			stall_left = $urandom_range(0, recv_gap_max);
			if (pending_medians.size() == 0) begin
				report_mismatch($sformatf("median item %p with none expected", median_item));
			end else begin
				want = pending_medians.pop_front();
				medians_seen[want.set_kind]++;
				if (median_item.set_kind !== want.set_kind)
					report_mismatch($sformatf("set_kind %b, expected %b",
						median_item.set_kind, want.set_kind));
				if (median_item.fwd_median !== want.fwd_median)
					report_mismatch($sformatf("fwd_median %0d, expected %0d",
						median_item.fwd_median, want.fwd_median));
				if (median_item.ref_median !== want.ref_median)
					report_mismatch($sformatf("ref_median %0d, expected %0d",
						median_item.ref_median, want.ref_median));
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (median_valid && !median_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without progress, %0d medians pending",
				idle_cycles, pending_medians.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		reflected_next = 1'b0;
		last_fwd_set = SET_NORMAL;
		for (int s = 0; s < 2; s++) begin
			pair_fill[s] = 0;
			fwd_written[s] = '0;
			medians_seen[s] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed;
		test_random_sets(700);
		test_drain_pause;
		test_back_to_back(150);
		test_random_sets(1150);

		@(negedge clk);
		sample_valid <= 1'b0;
		wait (pending_medians.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples, %0d normal and %0d known-set medians",
			items_sent, medians_seen[SET_NORMAL], medians_seen[SET_KNOWN]);
		$display("split pairs %0d, known closes with load still requested %0d",
			mixed_pairs, forced_normal);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
